// ===== hdl/stcb_pkg.sv =====
package stcb_pkg;

  // Every coordinate field of a transaction is this wide.
  localparam int CoordBits = 10;

  // Default arena size.
  localparam int ArenaWidthDef  = 1024;
  localparam int ArenaHeightDef = 1024;

  // Bits per bitmap memory word; one word holds a run of cells of one row.
  localparam int WordBits = 32;

  // Walker accumulator: holds up to 2*|dx| + 2*|dy|.
  localparam int AccBits = CoordBits + 2;

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic {
    OP_TRACE = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_RD,
    S_WR,
    S_DONE
  } state_e;

  // Bitmap control from the sequencer.
  typedef struct packed {
    logic rd;         // read the word holding the current cell
    logic wr;         // write it back with the cell set
    logic clr_start;  // start a clearing sweep
  } bm_ctrl_t;

  // Walker control from the sequencer.
  typedef struct packed {
    logic load;  // take a new segment
    logic step;  // advance to the next cell
  } walk_ctrl_t;

endpackage

// ===== hdl/segment_trace_collision_bitmap.sv =====
// Segment tracer over a one-bit occupancy bitmap of the arena.
// Input stream: tuser is the operation (0 trace, 1 clear); tdata carries
// start_x, start_y, end_x, end_y. Output stream: one transaction per input,
// tdata bit 0 collision, bit 1 out_of_range.
// A trace marks every cell from just past the start through the end and
// reports whether any of them was already set. Each cell is a read-modify-
// write of one word of the single-port bitmap memory, read in S_RD and
// written back in S_WR. Out-of-range and zero-length traces skip the walk.
// A clear sweeps the memory one word per cycle. The memory holds
// 2^(clog2(ARENA_HEIGHT) + max(clog2(ARENA_WIDTH) - 5, 0)) words,
// 32768 at 1024 x 1024.
// The same sweep runs after reset; tready stays low until it ends.
// One item is in work at a time; tready is low while it runs.
// The result sits in an output register: a stalled receiver does not keep
// the next item from being accepted, but that item's result waits until the
// register is free.
module segment_trace_collision_bitmap
  import stcb_pkg::*;
#(
  parameter int ARENA_WIDTH  = ArenaWidthDef,
  parameter int ARENA_HEIGHT = ArenaHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] start_x, [19:10] start_y, [29:20] end_x, [39:30] end_y
  input  logic [39:0] s_axis_tdata_i,
  // [0] operation
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] collision, [1] out_of_range, [7:2] zero
  output logic [7:0]  m_axis_tdata_o
);

  state_e     state_q, state_d;
  bm_ctrl_t   bm_ctrl;
  walk_ctrl_t wk_ctrl;
  logic       bm_busy, bm_hit, wk_last;
  coord_t     cx, cy;
  coord_t     sx, sy, ex, ey;
  logic       in_hs, out_range;
  logic       coll_q, coll_d, oor_q, oor_d;
  logic       m_valid_q, out_load;
  logic [1:0] m_data_q;

  assign sx = s_axis_tdata_i[9:0];
  assign sy = s_axis_tdata_i[19:10];
  assign ex = s_axis_tdata_i[29:20];
  assign ey = s_axis_tdata_i[39:30];

  assign out_range = (32'(sx) >= ARENA_WIDTH) || (32'(ex) >= ARENA_WIDTH) ||
                     (32'(sy) >= ARENA_HEIGHT) || (32'(ey) >= ARENA_HEIGHT);

  assign s_axis_tready_o = (state_q == S_IDLE) && !bm_busy;
  assign in_hs           = s_axis_tvalid_i && s_axis_tready_o;

  stcb_bitmap #(
    .ARENA_WIDTH  (ARENA_WIDTH),
    .ARENA_HEIGHT (ARENA_HEIGHT)
  ) u_bitmap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (bm_ctrl),
    .cx_i   (cx),
    .cy_i   (cy),
    .hit_o  (bm_hit),
    .busy_o (bm_busy)
  );

  stcb_walker u_walker (
    .clk_i  (clk_i),
    .ctrl_i (wk_ctrl),
    .sx_i   (sx),
    .sy_i   (sy),
    .ex_i   (ex),
    .ey_i   (ey),
    .cx_o   (cx),
    .cy_o   (cy),
    .last_o (wk_last)
  );

  always_comb begin
    state_d  = state_q;
    bm_ctrl  = '0;
    wk_ctrl  = '0;
    coll_d   = coll_q;
    oor_d    = oor_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          coll_d = 1'b0;
          oor_d  = 1'b0;
          if (op_e'(s_axis_tuser_i) == OP_CLEAR) begin
            bm_ctrl.clr_start = 1'b1;
            state_d           = S_CLR;
          end else if (out_range) begin
            oor_d   = 1'b1;
            state_d = S_DONE;
          end else if (sx == ex && sy == ey) begin
            state_d = S_DONE;
          end else begin
            wk_ctrl.load = 1'b1;
            state_d      = S_RD;
          end
        end
      end
      S_CLR: begin
        if (!bm_busy) state_d = S_DONE;
      end
      S_RD: begin
        bm_ctrl.rd = 1'b1;
        state_d    = S_WR;
      end
      S_WR: begin
        bm_ctrl.wr   = 1'b1;
        wk_ctrl.step = 1'b1;
        if (bm_hit) coll_d = 1'b1;
        state_d = wk_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      coll_q    <= 1'b0;
      oor_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      coll_q  <= coll_d;
      oor_q   <= oor_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= {oor_q, coll_q};
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, m_data_q};

  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(s_axis_tready_o && bm_busy))
    else $error("input accepted during bitmap clear");

  a_clear_starts_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_hs && s_axis_tuser_i) |=> bm_busy)
    else $error("clear transaction did not start a sweep");

  a_read_then_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_RD) |=> (state_q == S_WR))
    else $error("cell read not followed by write-back");

  a_oor_no_collision: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("out-of-range result reports a collision");

endmodule

// ===== hdl/stcb_bitmap.sv =====
module stcb_bitmap
  import stcb_pkg::*;
#(
  parameter int ARENA_WIDTH  = ArenaWidthDef,
  parameter int ARENA_HEIGHT = ArenaHeightDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bm_ctrl_t ctrl_i,
  input  coord_t   cx_i,
  input  coord_t   cy_i,
  output logic     hit_o,
  output logic     busy_o
);

  localparam int XBits    = $clog2(ARENA_WIDTH);
  localparam int YBits    = $clog2(ARENA_HEIGHT);
  localparam int OffBits  = $clog2(WordBits);
  localparam int XWBits   = (XBits > OffBits) ? XBits - OffBits : 0;
  localparam int AddrBits = YBits + XWBits;
  localparam int Depth    = 2 ** AddrBits;

  logic [WordBits-1:0] mem [Depth];
  logic [WordBits-1:0] rdata_q;
  logic [WordBits-1:0] mask;
  logic [AddrBits-1:0] addr;
  logic [AddrBits-1:0] clr_ptr_q, clr_ptr_d;
  logic                busy_q, busy_d;
  logic [OffBits-1:0]  bit_sel;

  // Row-major, each row padded to a power-of-two number of words.
  assign addr    = (AddrBits'(cy_i) << XWBits) | AddrBits'(cx_i >> OffBits);
  assign bit_sel = cx_i[OffBits-1:0];
  assign mask    = WordBits'(1) << bit_sel;
  assign hit_o   = rdata_q[bit_sel];
  assign busy_o  = busy_q;

  always_comb begin
    busy_d    = busy_q;
    clr_ptr_d = clr_ptr_q;
    if (busy_q) begin
      clr_ptr_d = clr_ptr_q + AddrBits'(1);
      if (&clr_ptr_q) busy_d = 1'b0;
    end else if (ctrl_i.clr_start) begin
      busy_d    = 1'b1;
      clr_ptr_d = '0;
    end
  end

  // Reset starts a sweep so the bitmap comes up all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_ptr_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_ptr_q <= clr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_ptr_q] <= '0;
    end else if (ctrl_i.wr) begin
      mem[addr] <= rdata_q | mask;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[addr];
    end
  end

endmodule

// ===== hdl/stcb_walker.sv =====
module stcb_walker
  import stcb_pkg::*;
(
  input  logic       clk_i,
  input  walk_ctrl_t ctrl_i,
  input  coord_t     sx_i,
  input  coord_t     sy_i,
  input  coord_t     ex_i,
  input  coord_t     ey_i,
  output coord_t     cx_o,
  output coord_t     cy_o,
  output logic       last_o
);

  coord_t               cx_q, cy_q, cnt_q;
  logic [AccBits-1:0]   acc_q;
  logic [CoordBits:0]   adx2_q, ady2_q;
  logic                 xup_q, yup_q, vert_q;

  logic                 xup, yup, vert;
  coord_t               adx, ady;
  logic [AccBits:0]     sub;
  logic                 ge;
  logic [AccBits-1:0]   acc_add;

  assign xup  = ex_i > sx_i;
  assign yup  = ey_i > sy_i;
  assign adx  = xup ? ex_i - sx_i : sx_i - ex_i;
  assign ady  = yup ? ey_i - sy_i : sy_i - ey_i;
  assign vert = (adx == '0);

  // Shared step unit: acc tracks 2*k*|dy| + |dx| - 2*|dx|*row_offset.
  // acc >= 2|dx| means the target row of this column is not reached yet.
  assign sub     = {1'b0, acc_q} - (AccBits + 1)'(adx2_q);
  assign ge      = ~sub[AccBits];
  assign acc_add = acc_q + AccBits'(ady2_q);

  assign cx_o   = cx_q;
  assign cy_o   = cy_q;
  assign last_o = (cnt_q == coord_t'(1)) && (vert_q || !ge);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      xup_q  <= xup;
      yup_q  <= yup;
      vert_q <= vert;
      adx2_q <= {adx, 1'b0};
      ady2_q <= {ady, 1'b0};
      acc_q  <= AccBits'(adx) + AccBits'({ady, 1'b0});
      cnt_q  <= vert ? ady : adx;
      if (vert) begin
        cx_q <= sx_i;
        cy_q <= yup ? sy_i + coord_t'(1) : sy_i - coord_t'(1);
      end else begin
        cx_q <= xup ? sx_i + coord_t'(1) : sx_i - coord_t'(1);
        cy_q <= sy_i;
      end
    end else if (ctrl_i.step) begin
      if (vert_q) begin
        cy_q  <= yup_q ? cy_q + coord_t'(1) : cy_q - coord_t'(1);
        cnt_q <= cnt_q - coord_t'(1);
      end else if (ge) begin
        acc_q <= sub[AccBits-1:0];
        cy_q  <= yup_q ? cy_q + coord_t'(1) : cy_q - coord_t'(1);
      end else begin
        acc_q <= acc_add;
        cnt_q <= cnt_q - coord_t'(1);
        cx_q  <= xup_q ? cx_q + coord_t'(1) : cx_q - coord_t'(1);
      end
    end
  end

endmodule

// ===== tb/segment_trace_collision_bitmap_test.sv =====
`timescale 1ns / 1ps

module segment_trace_collision_bitmap_test;
  import stcb_pkg::*;

  localparam int ArenaW = ArenaWidthDef;
  localparam int ArenaH = ArenaHeightDef;
  // Clear sweep covers 32768 words; the longest trace marks 2046 cells.
  localparam int IdleLimit = 200000;
  localparam int DrainLimit = 100000;
  localparam int TailCycles = 40;
  localparam int LongHold = 400;

  typedef struct packed {
    logic out_of_range;
    logic collision;
  } outcome_t;

  typedef enum int {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  // Model copy of the arena: cell_marked[y][x].
  bit [ArenaW-1:0] cell_marked [ArenaH];
  outcome_t pending_outcomes [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  segment_trace_collision_bitmap #(
    .ARENA_WIDTH (ArenaW),
    .ARENA_HEIGHT(ArenaH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic mark_run(bit vertical, int fixed, int a, int b);
    int lo;
    int hi;
    int x;
    int y;
    logic hit;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hit = 1'b0;
    for (int i = lo; i <= hi; i++) begin
      x = vertical ? fixed : i;
      y = vertical ? i : fixed;
      if (cell_marked[y][x]) hit = 1'b1;
      cell_marked[y][x] = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic trace_collides(int sx, int sy, int ex, int ey);
    bit x_up;
    bit y_up;
    int adx;
    int ady;
    int off;
    int col;
    int row;
    int prev_row;
    logic hit;
    x_up = ex > sx;
    y_up = ey > sy;
    adx = x_up ? ex - sx : sx - ex;
    ady = y_up ? ey - sy : sy - ey;
    hit = 1'b0;
    if (adx == 0 && ady == 0) return 1'b0;
    if (adx == 0) return mark_run(1'b1, sx, y_up ? sy + 1 : sy - 1, ey);
    if (ady == 0) return mark_run(1'b0, sy, x_up ? sx + 1 : sx - 1, ex);
    // Column walk; row offset rounded half away from zero.
    prev_row = sy;
    for (int k = 1; k <= adx; k++) begin
      off = (2 * k * ady + adx) / (2 * adx);
      col = x_up ? sx + k : sx - k;
      row = y_up ? sy + off : sy - off;
      if (mark_run(1'b1, col, prev_row, row)) hit = 1'b1;
      prev_row = row;
    end
    return hit;
  endfunction

  function automatic outcome_t predict_outcome(op_e op, coord_t sx, coord_t sy,
                                               coord_t ex, coord_t ey);
    outcome_t res;
    res = '0;
    if (op == OP_CLEAR) begin
      foreach (cell_marked[r]) cell_marked[r] = '0;
    end else if (int'(sx) >= ArenaW || int'(ex) >= ArenaW ||
                 int'(sy) >= ArenaH || int'(ey) >= ArenaH) begin
      res.out_of_range = 1'b1;
    end else begin
      res.collision = trace_collides(int'(sx), int'(sy), int'(ex), int'(ey));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- driver

  task automatic send_item(op_e op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(1, 10);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {ey, ex, sy, sx};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    pending_outcomes.push_back(predict_outcome(op, sx, sy, ex, ey));
  endtask

  task automatic send_trace(int sx, int sy, int ex, int ey);
    send_item(OP_TRACE, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
  endtask

  task automatic send_clear();
    // coordinates are don't-care on a clear
    send_item(OP_CLEAR, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom));
  endtask

  // Random traffic: short segments packed into a small window so that they
  // overlap, a few full-arena segments, and clears when clear_odds > 0.
  task automatic send_random_mix(int count, int clear_odds);
    int span;
    int wx;
    int wy;
    int pick;
    int sx;
    int sy;
    span = 16;
    wx = 0;
    wy = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        span = $urandom_range(4, 48);
        wx = $urandom_range(0, ArenaW - span);
        wy = $urandom_range(0, ArenaH - span);
      end
      pick = $urandom_range(0, 99);
      sx = wx + $urandom_range(0, span - 1);
      sy = wy + $urandom_range(0, span - 1);
      if (clear_odds > 0 && $urandom_range(1, clear_odds) == 1) begin
        send_clear();
      end else if (pick < 3) begin
        send_trace($urandom_range(0, ArenaW - 1), $urandom_range(0, ArenaH - 1),
                   $urandom_range(0, ArenaW - 1), $urandom_range(0, ArenaH - 1));
      end else if (pick < 10) begin
        send_trace(sx, sy, sx, wy + $urandom_range(0, span - 1));
      end else if (pick < 17) begin
        send_trace(sx, sy, wx + $urandom_range(0, span - 1), sy);
      end else if (pick < 20) begin
        send_trace(sx, sy, sx, sy);
      end else begin
        send_trace(sx, sy, wx + $urandom_range(0, span - 1),
                   wy + $urandom_range(0, span - 1));
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : result_sink
    sink_mode_e mode;
    int mode_left;
    logic [7:0] pattern;
    mode = SINK_ALWAYS;
    mode_left = 0;
    pattern = 8'hff;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 128);
        pattern = 8'($urandom);
      end
      mode_left--;
      case (mode)
        SINK_ALWAYS: m_axis_tready_i <= 1'b1;
        SINK_RANDOM: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default: begin
          m_axis_tready_i <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch($sformatf("result with none expected, tdata=%h", m_axis_tdata_o));
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (m_axis_tdata_o[0] !== exp_res.collision)
          note_mismatch($sformatf("collision expected %b actual %b",
                                  exp_res.collision, m_axis_tdata_o[0]));
        if (m_axis_tdata_o[1] !== exp_res.out_of_range)
          note_mismatch($sformatf("out_of_range expected %b actual %b",
                                  exp_res.out_of_range, m_axis_tdata_o[1]));
        if (m_axis_tdata_o[7:2] !== 6'd0)
          note_mismatch($sformatf("padding expected 0 actual %b", m_axis_tdata_o[7:2]));
      end
    end
  end

  // Counts cycles with no transaction on either side; ends the run at IdleLimit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles",
               $realtime, IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    send_item(OP_CLEAR, '1, '1, '1, '1);
    send_trace(0, 0, 0, 0);
    send_trace(1023, 1023, 1023, 1023);
    send_trace(5, 5, 5, 20);
    send_trace(6, 20, 6, 5);
    send_trace(5, 30, 40, 30);
    send_trace(40, 31, 5, 31);
    send_trace(5, 10, 5, 25);        // overlaps the first vertical run
    send_trace(100, 100, 110, 103);
    send_trace(110, 200, 100, 197);
    send_trace(200, 200, 203, 230);
    send_trace(303, 230, 300, 200);
    send_trace(400, 400, 402, 401);  // exact halves round away from zero
    send_trace(400, 410, 404, 411);
    send_trace(410, 420, 406, 417);
    send_trace(0, 0, 1023, 1023);
    send_trace(1023, 0, 0, 1023);
    send_trace(0, 1023, 1023, 1023);
    send_trace(1023, 1022, 1023, 0);
    send_trace(100, 100, 110, 103);  // same segment again
    send_item(OP_CLEAR, '0, '0, '0, '0);
    send_trace(100, 100, 110, 103);  // bitmap is empty again
    send_trace(0, 0, 1, 0);
    send_trace(1, 1, 0, 0);
  endtask

  task automatic test_clustered_traces();
    send_random_mix(300, 0);
  endtask

  task automatic test_receiver_hold_off();
    hold_request = 1'b1;
    burst_left = 200;
    send_random_mix(60, 0);
  endtask

  task automatic test_traces_with_clears();
    send_random_mix(240, 60);
  endtask

  initial begin : stimulus
    int waited;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_clustered_traces();
    test_receiver_hold_off();
    test_traces_with_clears();
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      $display("%0d expected results never arrived", pending_outcomes.size());
    end
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/stcb_pkg.sv
hdl/stcb_bitmap.sv
hdl/stcb_walker.sv
hdl/segment_trace_collision_bitmap.sv
tb/segment_trace_collision_bitmap_test.sv
